/* hdl/fcst_pkg.sv */
`timescale 1ns / 1ps

package fcst_pkg;

  localparam int MAX_STRIDE = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int ARC_LENGTH = 10;

  localparam int WIN        = 7;
  localparam int STORE_ROWS = 6;
  localparam int CIRCLE     = 16;
  localparam int PIX_W      = 8;
  localparam int MARGIN     = 3;

  localparam int COL_W = $clog2(MAX_STRIDE);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int CORNER_X_W = 11;
  localparam int CORNER_Y_W = 12;

  localparam int THR_W    = 8;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int STRIDE_W = 12;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 2'd3;

  localparam int STORE_W = STORE_ROWS * PIX_W;

  // window row and column of each circle point, clockwise from the top
  localparam int RING_ROW [CIRCLE] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
  localparam int RING_COL [CIRCLE] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

  typedef struct packed {
    logic             valid;
    logic             qual;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
  } tag_t;

endpackage

/* hdl/fcst_arc.sv */
`timescale 1ns / 1ps

module fcst_arc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  fcst_pkg::tag_t       tag_in,
  input  logic [7:0]           ring [fcst_pkg::CIRCLE],
  input  logic [7:0]           centre,
  input  logic [7:0]           thr,
  output fcst_pkg::tag_t       tag_out,
  output logic                 hit
);
  import fcst_pkg::*;

  logic [PIX_W:0]      sum;
  logic [PIX_W-1:0]    lo;
  logic [PIX_W-1:0]    hi;
  logic [CIRCLE-1:0]   bright_nxt;
  logic [CIRCLE-1:0]   dark_nxt;
  logic [CIRCLE-1:0]   bright_r;
  logic [CIRCLE-1:0]   dark_r;
  logic [CIRCLE-1:0]   start_hit;
  tag_t                tag_r;

  always_comb begin
    sum = {1'b0, centre} + {1'b0, thr};
    lo  = (centre > thr) ? (centre - thr) : '0;
    hi  = sum[PIX_W] ? {PIX_W{1'b1}} : sum[PIX_W-1:0];
    for (int k = 0; k < CIRCLE; k++) begin
      bright_nxt[k] = ring[k] > hi;
      dark_nxt[k]   = ring[k] < lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (adv) begin
      tag_r.valid <= tag_in.valid;
    end
    if (adv) begin
      tag_r.qual <= tag_in.qual;
      tag_r.x    <= tag_in.x;
      tag_r.y    <= tag_in.y;
      bright_r   <= bright_nxt;
      dark_r     <= dark_nxt;
    end
  end

  // a run may start at any circle point and wrap past the top
  always_comb begin
    for (int k = 0; k < CIRCLE; k++) begin
      logic all_b;
      logic all_d;
      all_b = 1'b1;
      all_d = 1'b1;
      for (int j = 0; j < ARC_LENGTH; j++) begin
        all_b = all_b & bright_r[(k + j) % CIRCLE];
        all_d = all_d & dark_r[(k + j) % CIRCLE];
      end
      start_hit[k] = all_b | all_d;
    end
  end

  assign hit     = |start_hit;
  assign tag_out = tag_r;

endmodule

/* hdl/fast_corner_segment_test.sv */
`timescale 1ns / 1ps
// a corner passes the s1, s2, arc and output registers after its pixel beat is taken before it shows on the out_ beat
// throughput: one pixel per cycle while in_stall is low, set by the single read and write port of the line store
// the line store is read as a pixel is taken and written back from stage s1, same-column reads are forwarded
// the output has a skid register, in_stall rises while both output registers are full
// synchronous reset clears counters and valids, in_stall stays high until run_r sets after reset

module fast_corner_segment_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_pixel,
  input  logic                                in_start_of_frame,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fcst_pkg::CORNER_X_W-1:0]     out_corner_x,
  output logic [fcst_pkg::CORNER_Y_W-1:0]     out_corner_y,
  input  logic                                cfg_we,
  input  logic [fcst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcst_pkg::CFG_W-1:0]          cfg_wdata
);
  import fcst_pkg::*;

  // configuration
  logic [THR_W-1:0]    thr_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [STRIDE_W-1:0] stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_W'(20);
      width_r  <= WIDTH_W'(640);
      height_r <= HEIGHT_W'(480);
      stride_r <= STRIDE_W'(640);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:    thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        CFG_LINE_STRIDE:  stride_r <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COL_W:0] eff_stride;
  logic [ROW_W:0] eff_height;
  logic [COL_W:0] eff_width;

  always_comb begin
    if (stride_r == '0)
      eff_stride = (COL_W+1)'(1);
    else if (32'(stride_r) > 32'(MAX_STRIDE))
      eff_stride = (COL_W+1)'(MAX_STRIDE);
    else
      eff_stride = (COL_W+1)'(stride_r);

    if (height_r == '0)
      eff_height = (ROW_W+1)'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT))
      eff_height = (ROW_W+1)'(MAX_HEIGHT);
    else
      eff_height = (ROW_W+1)'(height_r);

    if (32'(width_r) < 32'(eff_stride))
      eff_width = (COL_W+1)'(width_r);
    else
      eff_width = eff_stride;
  end

  // handshake and pipeline advance
  logic run_r;
  logic skid_valid_r;
  logic adv;
  logic accept;

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r || !run_r;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) run_r <= 1'b0;
    else        run_r <= 1'b1;
  end

  // position counters
  logic [COL_W-1:0] col_r, col_nxt, col0;
  logic [ROW_W-1:0] row_r, row_nxt, row0;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             qual0;

  always_comb begin
    col0    = in_start_of_frame ? '0 : col_r;
    row0    = in_start_of_frame ? '0 : row_r;
    col_inc = {1'b0, col0} + (COL_W+1)'(1);
    row_inc = {1'b0, row0} + (ROW_W+1)'(1);
    if (col_inc >= eff_stride) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_height) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row0;
    end
    qual0 = (32'(col0) >= 32'(2 * MARGIN)) && ({1'b0, col0} < eff_width)
            && (32'(row0) >= 32'(2 * MARGIN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: one column of six earlier rows per address
  logic [STORE_W-1:0] store_mem [MAX_STRIDE];
  logic [STORE_W-1:0] rdata_r;
  logic [STORE_W-1:0] fwd_data_r;
  logic               fwd_r;
  logic [STORE_W-1:0] col_data;
  logic [STORE_W-1:0] wdata;
  logic               s1_valid_r;
  logic               s1_qual_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [PIX_W-1:0]   s1_pixel_r;
  logic               wr_en;

  assign wr_en    = adv && s1_valid_r;
  assign col_data = fwd_r ? fwd_data_r : rdata_r;
  // drop the oldest row, push the new pixel on top
  assign wdata    = {s1_pixel_r, col_data[STORE_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (adv) rdata_r <= store_mem[col0];
    if (wr_en) store_mem[s1_col_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
      fwd_r      <= s1_valid_r && (s1_col_r == col0);
    end
    if (adv) begin
      fwd_data_r <= wdata;
      s1_qual_r  <= qual0;
      s1_col_r   <= col0;
      s1_row_r   <= row0;
      s1_pixel_r <= in_pixel;
    end
  end

  // 7x7 window, newest column on the right
  logic [PIX_W-1:0] win_r [WIN][WIN];
  logic [PIX_W-1:0] new_col [WIN];

  always_comb begin
    for (int r = 0; r < STORE_ROWS; r++) new_col[r] = col_data[r*PIX_W +: PIX_W];
    new_col[WIN-1] = s1_pixel_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) win_r[r][c] <= win_r[r][c+1];
        win_r[r][WIN-1] <= new_col[r];
      end
    end
  end

  tag_t s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.valid <= 1'b0;
    end else if (adv) begin
      s2_tag_r.valid <= s1_valid_r;
    end
    if (adv) begin
      s2_tag_r.qual <= s1_qual_r;
      s2_tag_r.x    <= s1_col_r - COL_W'(MARGIN);
      s2_tag_r.y    <= s1_row_r - ROW_W'(MARGIN);
    end
  end

  logic [PIX_W-1:0] ring [CIRCLE];

  for (genvar k = 0; k < CIRCLE; k++) begin : g_ring
    assign ring[k] = win_r[RING_ROW[k]][RING_COL[k]];
  end

  tag_t s3_tag;
  logic arc_hit;

  fcst_arc u_arc (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .tag_in  (s2_tag_r),
    .ring    (ring),
    .centre  (win_r[MARGIN][MARGIN]),
    .thr     (thr_r),
    .tag_out (s3_tag),
    .hit     (arc_hit)
  );

  // output register with skid
  logic                  res_v;
  logic                  out_valid_r;
  logic [COL_W-1:0]      out_x_r, skid_x_r;
  logic [ROW_W-1:0]      out_y_r, skid_y_r;

  assign res_v = adv && s3_tag.valid && s3_tag.qual && arc_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (res_v) skid_valid_r <= 1'b1;
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (res_v) begin
        skid_x_r <= s3_tag.x;
        skid_y_r <= s3_tag.y;
      end
    end else if (skid_valid_r) begin
      out_x_r <= skid_x_r;
      out_y_r <= skid_y_r;
    end else begin
      out_x_r <= s3_tag.x;
      out_y_r <= s3_tag.y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_corner_x = CORNER_X_W'(out_x_r);
  assign out_corner_y = CORNER_Y_W'(out_y_r);

endmodule

/* hdl/fcst_checker.sv */
`timescale 1ns / 1ps

module fcst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [fcst_pkg::CORNER_X_W-1:0]   out_corner_x,
  input logic [fcst_pkg::CORNER_Y_W-1:0]   out_corner_y
);
  import fcst_pkg::*;

  // reset leaves no beat on the output
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_corner_x) && $stable(out_corner_y))
    else $error("stalled result beat changed");

  // a corner never lies within the top or left border of three pixels
  a_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_corner_x >= CORNER_X_W'(MARGIN)) && (out_corner_y >= CORNER_Y_W'(MARGIN)))
    else $error("corner inside border");

  // input stalls only while the output register holds a result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && $past(rst_n) |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind fast_corner_segment_test fcst_checker u_fcst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_corner_x (out_corner_x),
  .out_corner_y (out_corner_y)
);
